// ===== rtl/chunked_length_checksum_framer_unit_macros.svh =====
// Assertion macros for the framer RTL.
`ifndef CHUNKED_LENGTH_CHECKSUM_FRAMER_UNIT_MACROS_SVH
`define CHUNKED_LENGTH_CHECKSUM_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CLCF_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CLCF_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/clcf_pkg.sv =====
// Types and byte-kind codes for the chunked length/checksum framer.
package clcf_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] kind_t;

  // Output byte kinds
  localparam kind_t KIND_HEADER   = 2'd0;
  localparam kind_t KIND_PAYLOAD  = 2'd1;
  localparam kind_t KIND_CHECKSUM = 2'd2;

endpackage

// ===== rtl/clcf_buf.sv =====
// Chunk buffer: one write port, one registered read port.
module clcf_buf #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  clcf_pkg::byte_t  wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output clcf_pkg::byte_t  rdata
);

  clcf_pkg::byte_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/chunked_length_checksum_framer_unit.sv =====
// Top level of the chunked length-prefixed framer with two's complement checksum.
//
// Input stream (s_*): one message byte per transfer in s_tdata, s_tlast marks the
// last byte of a message, s_tuser marks an empty end-of-message (data ignored).
// Output stream (m_*): frame bytes in m_tdata, m_tuser gives the byte kind
// (header, payload, checksum), m_tlast marks the last byte caused by one input.
// Bytes are buffered up to CHUNK; a full buffer or the end of a message sends a
// frame: header (count+1), payload, checksum. A message ends with frame 01 FF.
// Timing: a byte that sends nothing leaves s_tready high. Otherwise s_tready
// stays low while the sequencer walks the frame(s), one output byte per cycle
// through the output register while m_tready is high. The single 8-bit adder
// that accumulates the sum and the one-port buffer read set that rate.
// After the accept, the sequencer loads the header of the first frame from HDR
// into the output register once that register can advance, and it shows on m_*.
// When the receiver stalls, the output register holds and the sequencer waits.
// Reset clears the fill count, the sum and the output valid; buffer contents are
// left as they are and only entries written after the last flush are read.
`include "chunked_length_checksum_framer_unit_macros.svh"

module chunked_length_checksum_framer_unit #(
  parameter int CHUNK = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_message
  input  logic       s_tuser,   // [0] empty_message
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] tx_byte
  output logic       m_tlast,   // run_last
  output logic [1:0] m_tuser    // [1:0] byte_kind
);

  localparam int CW = $clog2(CHUNK + 1);
  localparam int AW = (CHUNK > 1) ? $clog2(CHUNK) : 1;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_PAY  = 2'd2;
  localparam logic [1:0] S_CHK  = 2'd3;

  logic [1:0]      state;
  logic [CW-1:0]   fill;
  logic [AW-1:0]   idx;
  clcf_pkg::byte_t sum;
  logic            term_pend;

  clcf_pkg::byte_t out_byte;
  clcf_pkg::kind_t out_kind;
  logic            out_last;
  logic            out_valid;

  logic            accept;
  logic            adv;
  logic [CW-1:0]   fill_inc;
  logic [CW-1:0]   idx_inc;
  clcf_pkg::byte_t hdr;
  clcf_pkg::byte_t add_b;
  clcf_pkg::byte_t add_sum;
  clcf_pkg::byte_t rd_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign adv      = !out_valid || m_tready;

  assign fill_inc = fill + CW'(1);
  assign idx_inc  = CW'(idx) + CW'(1);
  assign hdr      = 8'(fill) + 8'd1;

  // Shared 8-bit adder: byte accumulation on accept, header fold-in at HDR
  assign add_b   = (state == S_HDR) ? hdr : s_tdata;
  assign add_sum = sum + add_b;

  // Buffer reads: first entry at header time, next entry on each payload byte
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (adv && state == S_HDR) begin
      rd_en   = (fill != '0);
      rd_addr = '0;
    end else if (adv && state == S_PAY) begin
      rd_en   = (idx_inc < fill);
      rd_addr = idx_inc[AW-1:0];
    end
  end

  clcf_buf #(
    .DEPTH (CHUNK),
    .AW    (AW)
  ) u_buf (
    .clk   (clk),
    .we    (accept && !s_tuser),
    .waddr (fill[AW-1:0]),
    .wdata (s_tdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Sequencer and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      sum       <= '0;
      term_pend <= 1'b0;
      idx       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              // Flush what is buffered, then the terminator
              state     <= S_HDR;
              term_pend <= (fill != '0);
            end else begin
              fill <= fill_inc;
              sum  <= add_sum;
              if (fill_inc == CW'(CHUNK) || s_tlast) begin
                state     <= S_HDR;
                term_pend <= s_tlast;
              end
            end
          end
        end
        S_HDR: begin
          if (adv) begin
            sum   <= add_sum;
            idx   <= '0;
            state <= (fill != '0) ? S_PAY : S_CHK;
          end
        end
        S_PAY: begin
          if (adv) begin
            idx   <= idx_inc[AW-1:0];
            state <= (idx_inc == fill) ? S_CHK : S_PAY;
          end
        end
        S_CHK: begin
          if (adv) begin
            fill      <= '0;
            sum       <= '0;
            term_pend <= 1'b0;
            state     <= term_pend ? S_HDR : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= (state != S_IDLE);
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (state)
        S_HDR: begin
          out_byte <= hdr;
          out_kind <= clcf_pkg::KIND_HEADER;
          out_last <= 1'b0;
        end
        S_PAY: begin
          out_byte <= rd_data;
          out_kind <= clcf_pkg::KIND_PAYLOAD;
          out_last <= 1'b0;
        end
        S_CHK: begin
          out_byte <= 8'd0 - sum;
          out_kind <= clcf_pkg::KIND_CHECKSUM;
          out_last <= !term_pend;
        end
        default: begin
          out_byte <= out_byte;
          out_kind <= out_kind;
          out_last <= out_last;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  // Checks
  `CLCF_IMPLIES(a_fill_room, state == S_IDLE, fill < CW'(CHUNK), "buffer full while idle")
  `CLCF_IMPLIES(a_pay_index, state == S_PAY, CW'(idx) < fill, "payload index past fill")
  `CLCF_IMPLIES(a_last_idle, out_valid && out_last, state == S_IDLE || state == S_HDR, "run end mid-frame")
  `CLCF_IMPLIES(a_last_chk, out_valid && out_last, out_kind == clcf_pkg::KIND_CHECKSUM, "run end not on checksum")
  `CLCF_NEXT(a_chk_done, state == S_CHK && adv && !term_pend, fill == '0 && sum == '0, "no clear")

endmodule

// ===== bench/clcf_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the framer: predicts frame bytes from input transfers, checks output transfers.
module clcf_checker #(
  parameter int CHUNK = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_message
  input  logic       s_tuser,   // [0] empty_message
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] tx_byte
  input  logic       m_tlast,   // run_last
  input  logic [1:0] m_tuser,   // [1:0] byte_kind
  output int         fail_count,
  output int         expected_left
);

  typedef struct packed {
    clcf_pkg::byte_t tx;
    clcf_pkg::kind_t kind;
    logic            run_end;
  } frame_byte_t;

  // Expected output bytes, oldest first
  frame_byte_t frame_q[$];

  // Predictor state: buffered payload, fill level, 8-bit payload sum
  clcf_pkg::byte_t chunk_buf [CHUNK];
  int unsigned     buf_fill;
  clcf_pkg::byte_t buf_sum;
  int unsigned     result_idx;

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", result_idx, what, got, want);
  endtask

  task automatic push_byte(input clcf_pkg::byte_t tx, input clcf_pkg::kind_t kind);
    frame_byte_t fb;
    fb.tx      = tx;
    fb.kind    = kind;
    fb.run_end = 1'b0;
    frame_q.push_back(fb);
  endtask

  // One frame from the buffer (possibly empty): header, payload, checksum
  task automatic queue_frame();
    clcf_pkg::byte_t hdr;
    clcf_pkg::byte_t total;
    hdr   = clcf_pkg::byte_t'(buf_fill + 1);
    total = hdr + buf_sum;
    push_byte(hdr, clcf_pkg::KIND_HEADER);
    for (int i = 0; i < buf_fill; i++) push_byte(chunk_buf[i], clcf_pkg::KIND_PAYLOAD);
    push_byte(clcf_pkg::byte_t'(8'h00 - total), clcf_pkg::KIND_CHECKSUM);
    buf_fill = 0;
    buf_sum  = '0;
  endtask

  // Expected bytes caused by one accepted input transfer
  task automatic predict_frames(input clcf_pkg::byte_t data, input logic eom, input logic empty);
    int unsigned start_len;
    frame_byte_t fb;
    start_len = frame_q.size();
    if (empty) begin
      // empty end wins over the byte; flush what is buffered, then terminator
      if (buf_fill > 0) queue_frame();
      queue_frame();
    end else begin
      if (buf_fill < CHUNK) begin
        chunk_buf[buf_fill] = data;
        buf_fill++;
        buf_sum = buf_sum + data;
      end
      if (buf_fill >= CHUNK) queue_frame();
      if (eom) begin
        // a full buffer already went out, so no zero-length data frame here
        if (buf_fill > 0) queue_frame();
        queue_frame();
      end
    end
    if (frame_q.size() > start_len) begin
      fb = frame_q[frame_q.size() - 1];
      fb.run_end = 1'b1;
      frame_q[frame_q.size() - 1] = fb;
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      frame_q.delete();
      buf_fill      = 0;
      buf_sum       = '0;
      result_idx    = 0;
      fail_count    = 0;
      expected_left = 0;
    end else begin
      if (s_tvalid && s_tready) predict_frames(s_tdata, s_tlast, s_tuser);
      if (m_tvalid && m_tready) begin
        if (frame_q.size() == 0) begin
          report_mismatch("result with none expected, tdata", m_tdata, 0);
        end else begin
          want = frame_q.pop_front();
          if (m_tdata !== want.tx) report_mismatch("tx_byte", m_tdata, want.tx);
          if (m_tuser !== want.kind) report_mismatch("byte_kind", m_tuser, want.kind);
          if (m_tlast !== want.run_end) report_mismatch("run_last", m_tlast, want.run_end);
        end
        result_idx++;
      end
      expected_left = frame_q.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Top of the framer bench: clock, reset, input and output stream drivers, verdict.
module testbench;

  localparam int CHUNK       = 32;
  localparam int ITEM_TARGET = 270;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] data_byte
  logic       s_tlast;   // end_of_message
  logic       s_tuser;   // [0] empty_message
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] tx_byte
  logic       m_tlast;   // run_last
  logic [1:0] m_tuser;   // [1:0] byte_kind

  int fail_count;
  int expected_left;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int items_sent;
  int cycle_count;

  chunked_length_checksum_framer_unit #(.CHUNK(CHUNK)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  clcf_checker #(.CHUNK(CHUNK)) checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on a cycle counter
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[chunked_length_checksum_framer_unit] ERROR");
    $finish;
  end

  // Output side: random stalls, plus a long hold-off counted down here
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready = 1'b0;
      end else if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_item(input clcf_pkg::byte_t data, input logic eom, input logic empty);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = clcf_pkg::byte_t'($urandom);
      s_tlast  = 1'($urandom);
      s_tuser  = 1'($urandom);
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = data;
    s_tlast  = eom;
    s_tuser  = empty;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // A message of len random bytes; ends on tlast or on a separate empty end
  task automatic send_message(input int len, input logic empty_end);
    for (int i = 0; i < len; i++)
      send_item(clcf_pkg::byte_t'($urandom), (i == len - 1) && !empty_end, 1'b0);
    if (empty_end) send_item(clcf_pkg::byte_t'($urandom), 1'($urandom), 1'b1);
  endtask

  // Sender waits until every expected byte has arrived
  task automatic drain_outputs();
    s_tvalid = 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  initial begin
    int phase;
    int msg_idx;
    int len;
    int pick;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    s_tuser       = 1'b0;
    hold_left     = 0;
    items_sent    = 0;
    send_idle_pct = 35;
    recv_idle_pct = 56;
    rst           = 1'b1;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: empty message straight after reset gives the terminator only
    send_item(8'h5A, 1'b0, 1'b1);
    // one-byte messages at both data extremes
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    // bytes buffered, then an empty end flushes them before the terminator
    send_item(8'hAA, 1'b0, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'h3C, 1'b0, 1'b1);
    // both flags, nothing buffered: byte dropped
    send_item(8'hC3, 1'b1, 1'b1);
    // both flags with a byte buffered
    send_item(8'h12, 1'b0, 1'b0);
    send_item(8'h34, 1'b1, 1'b1);
    // sum wraps around
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'h7F, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    drain_outputs();

    // Random part, three idling phases
    phase   = 0;
    msg_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 0 && items_sent >= ITEM_TARGET / 3) begin
        phase = 1;
        drain_outputs();
        send_idle_pct = 56;
        recv_idle_pct = 35;
      end else if (phase == 1 && items_sent >= 2 * ITEM_TARGET / 3) begin
        phase = 2;
        drain_outputs();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long receiver hold-off while a message longer than a chunk is offered
        hold_left = HOLD_CYCLES;
        send_message(CHUNK + 8, 1'b0);
      end

      pick = int'($urandom_range(99));
      if (msg_idx == 0) begin
        // exactly one chunk: full frame then terminator, no empty data frame
        send_message(CHUNK, 1'b0);
      end else if (msg_idx == 1) begin
        send_message(2 * CHUNK, 1'b1);
      end else if (pick < 65) begin
        len = ($urandom_range(3) == 0) ? int'($urandom_range(40, 1))
                                       : int'($urandom_range(8, 1));
        send_message(len, 1'b0);
      end else if (pick < 80) begin
        send_message(int'($urandom_range(12, 1)), 1'b1);
      end else if (pick < 85) begin
        send_message(CHUNK * int'($urandom_range(2, 1)), 1'($urandom_range(1)));
      end else begin
        // noise: any flag combination
        send_item(clcf_pkg::byte_t'($urandom), 1'($urandom), 1'($urandom));
      end
      msg_idx++;
    end

    // Wind down
    s_tvalid = 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("[chunked_length_checksum_framer_unit] OK");
    end else begin
      $display("[chunked_length_checksum_framer_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== chunked_length_checksum_framer_unit.f =====
+incdir+rtl
rtl/clcf_pkg.sv
rtl/clcf_buf.sv
rtl/chunked_length_checksum_framer_unit.sv
bench/clcf_checker.sv
bench/testbench.sv
